[rtl/sctok_pkg.sv]
// shared types, event codes and character classes of the stylesheet tokenizer
`timescale 1ns / 1ps

package sctok_pkg;

    typedef enum logic [5:0] {
        ST_SELECTOR   = 6'b000001,
        ST_OPEN_BRACE = 6'b000010,
        ST_PROPNAME   = 6'b000100,
        ST_COLON      = 6'b001000,
        ST_PROPVAL    = 6'b010000,
        ST_NEXTPROP   = 6'b100000
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_IGNORED    = 4'd0,
        EV_SEL_CHAR   = 4'd1,
        EV_STYLE_BEG  = 4'd2,
        EV_NAME_CHAR  = 4'd3,
        EV_VAL_CHAR   = 4'd4,
        EV_PROP_DONE  = 4'd5,
        EV_STYLE_END  = 4'd6,
        EV_BRACE_ERR  = 4'd7,
        EV_COLON_ERR  = 4'd8,
        EV_STREAM_END = 4'd9
    } event_t;

    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

endpackage

[rtl/stylesheet_char_tokenizer_unit.sv]
// top level of the stylesheet character tokenizer
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [7:0] char_in                           | [0] kind
//  m_      | out | [7:0] char_out, [8] finished_ok, 0 pad  | [3:0] event_res
//
// one transaction per cycle unless stalled; each input byte yields one result
// the parser state and flags update at the input edge, the result register
// holds the event until taken
// aresetn (synchronous, active low) returns the parser to selector state
// a stalled result holds s_tready low only while m_tready is low
`timescale 1ns / 1ps

module stylesheet_char_tokenizer_unit import sctok_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_out, [8] finished_ok, [15:9] zero
    output logic [3:0]  m_tuser    // [3:0] event_res
);

    parse_state_t state_reg, state_next;
    logic         sel_started_reg, sel_started_next;
    logic         name_started_reg, name_started_next;
    logic         val_started_reg, val_started_next;

    logic         m_valid_reg;
    event_t       event_reg, event_next;
    logic [7:0]   char_reg, char_next;
    logic         fin_reg, fin_next;

    logic         s_accept;
    logic [7:0]   c;

    assign c        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next        = state_reg;
        sel_started_next  = sel_started_reg;
        name_started_next = name_started_reg;
        val_started_next  = val_started_reg;
        event_next        = EV_IGNORED;
        fin_next          = 1'b0;
        if (s_tuser[0]) begin
            fin_next          = (state_reg == ST_SELECTOR);
            event_next        = EV_STREAM_END;
            state_next        = ST_SELECTOR;
            sel_started_next  = 1'b0;
            name_started_next = 1'b0;
            val_started_next  = 1'b0;
        end else begin
            unique case (state_reg)
                ST_SELECTOR: begin
                    if (!sel_started_reg) begin
                        if (is_alpha(c) || c == CH_DOT) begin
                            sel_started_next = 1'b1;
                            event_next       = EV_SEL_CHAR;
                        end
                    end else if (c == CH_LBRACE) begin
                        state_next = ST_PROPNAME;
                        event_next = EV_STYLE_BEG;
                    end else if (is_space(c)) begin
                        state_next = ST_OPEN_BRACE;
                    end else if (is_alpha(c)) begin
                        event_next = EV_SEL_CHAR;
                    end
                end
                ST_OPEN_BRACE: begin
                    if (c == CH_LBRACE) begin
                        state_next = ST_PROPNAME;
                        event_next = EV_STYLE_BEG;
                    end else if (!is_space(c)) begin
                        event_next = EV_BRACE_ERR;
                    end
                end
                ST_PROPNAME: begin
                    if (!name_started_reg) begin
                        if (is_alpha(c)) begin
                            name_started_next = 1'b1;
                            event_next        = EV_NAME_CHAR;
                        end
                    end else if (is_space(c)) begin
                        state_next = ST_COLON;
                    end else if (c == CH_COLON) begin
                        state_next = ST_PROPVAL;
                    end else if (is_alnum(c) || c == CH_UNDERSCORE || c == CH_DASH) begin
                        event_next = EV_NAME_CHAR;
                    end
                end
                ST_COLON: begin
                    if (c == CH_COLON) begin
                        state_next = ST_PROPVAL;
                    end else if (!is_space(c)) begin
                        event_next = EV_COLON_ERR;
                    end
                end
                ST_PROPVAL: begin
                    if (!val_started_reg && is_space(c)) begin
                        event_next = EV_IGNORED;
                    end else if (val_started_reg && c == CH_SEMI) begin
                        state_next        = ST_NEXTPROP;
                        name_started_next = 1'b0;
                        val_started_next  = 1'b0;
                        event_next        = EV_PROP_DONE;
                    end else if (is_print(c)) begin
                        val_started_next = 1'b1;
                        event_next       = EV_VAL_CHAR;
                    end
                end
                ST_NEXTPROP: begin
                    if (c == CH_RBRACE) begin
                        state_next       = ST_SELECTOR;
                        sel_started_next = 1'b0;
                        event_next       = EV_STYLE_END;
                    end else if (is_alpha(c)) begin
                        state_next        = ST_PROPNAME;
                        name_started_next = 1'b1;
                        event_next        = EV_NAME_CHAR;
                    end
                end
                default: begin
                    event_next = EV_IGNORED;
                end
            endcase
        end
        char_next = (event_next == EV_SEL_CHAR || event_next == EV_NAME_CHAR ||
                     event_next == EV_VAL_CHAR) ? c : 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SELECTOR;
            sel_started_reg  <= 1'b0;
            name_started_reg <= 1'b0;
            val_started_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg        <= state_next;
                sel_started_reg  <= sel_started_next;
                name_started_reg <= name_started_next;
                val_started_reg  <= val_started_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            event_reg <= event_next;
            char_reg  <= char_next;
            fin_reg   <= fin_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, fin_reg, char_reg};
    assign m_tuser  = event_reg;

    // end of stream leaves the parser cleared
    a_stream_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser[0] |=> state_reg == ST_SELECTOR && !sel_started_reg &&
            !name_started_reg && !val_started_reg)
        else $error("parser not cleared after stream end");

    // char_out carries a byte only for text events
    a_char_only_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !(event_reg == EV_SEL_CHAR || event_reg == EV_NAME_CHAR ||
            event_reg == EV_VAL_CHAR) |-> char_reg == 8'h00)
        else $error("char_out set on a non-text event");

    // finished_ok only on stream end
    a_fin_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && fin_reg |-> event_reg == EV_STREAM_END)
        else $error("finished_ok outside stream end");

    // errors keep the parser state
    a_error_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (event_next == EV_BRACE_ERR || event_next == EV_COLON_ERR)
            |=> $stable(state_reg))
        else $error("state changed on a parse error");

endmodule
